// ===== rtl/core/ole_pkg.sv =====
// Shared types and codes for the ordered list engine.
// No dependencies.
`default_nettype none
package ole_pkg;
  localparam int DepthDefault = 16;
  localparam int ValueW = 32;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_DEL_LAST  = 2'd1,
    OP_SEARCH    = 2'd2,
    OP_DEL_AFTER = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;
endpackage
`default_nettype wire

// ===== rtl/core/ole_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module ole_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/ordered_list_engine_core.sv =====
// Ordered list engine: list held in a RAM, walked by a sequencer.
// Depends on ole_pkg and ole_ram.
`default_nettype none
// The list sits in one RAM (one write, one registered read per cycle) with
// the head at address 0. One request runs at a time. Search scans from the
// head to the first match or the end; delete-last reads the last entry;
// insert shifts every entry down one slot; delete-after scans to the match
// and shifts the tail up. Insert when full and any delete or search on an
// empty list go straight to the result. The single RAM read port paces
// every walk, and a stalled result beat holds up the sequencer.
// A new request is taken once the previous result has left the output
// register or is taken in the same cycle.
module ordered_list_engine_core #(
  parameter int Depth = ole_pkg::DepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // op[1:0], value[33:2], zero[39:34]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // status[1:0], removed_value[33:2],
                                      // entry_count[38:34], zero[39]
);
  import ole_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_INS, S_DLAST, S_SCAN, S_SHIFT, S_DONE
  } state_t;

  state_t state;
  op_t op;
  logic [ValueW-1:0] val, carry, removed;
  logic [CW-1:0] count, idx;
  status_t status;
  logic found;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [ValueW-1:0] wdata, rdata;

  ole_ram #(.Width(ValueW), .Depth(Depth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // Read address leads idx by one in scan and insert, by two in shift.
  logic [CW-1:0] ridx;
  always_comb begin
    we = 1'b0;
    waddr = idx[AW-1:0];
    wdata = carry;
    ridx = idx + CW'(1);
    case (state)
      S_IDLE:  ridx = '0;
      S_INS: begin
        // Write carried value at idx; rdata holds old entry at idx.
        we = 1'b1;
      end
      S_DLAST: ridx = count - CW'(1);
      S_SHIFT: begin
        // After the victim cycle rdata is entry idx+1; move it up to idx.
        we = !found && (idx + CW'(1) < count);
        wdata = rdata;
        if (!found) ridx = idx + CW'(2);
      end
      default: ;
    endcase
    raddr = (state == S_IDLE) ? '0 :
            (state == S_DLAST) ? ridx[AW-1:0] :
            (ridx < CW'(Depth)) ? ridx[AW-1:0] : '0;
  end

  logic primed;
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      m_tvalid <= 1'b0;
      primed <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            op <= op_t'(s_tdata[1:0]);
            val <= s_tdata[33:2];
            carry <= s_tdata[33:2];
            idx <= '0;
            primed <= 1'b0;
            removed <= '0;
            status <= ST_OK;
            found <= 1'b0;
            case (op_t'(s_tdata[1:0]))
              OP_INSERT: begin
                if (count == CW'(Depth)) begin
                  status <= ST_FULL; state <= S_DONE;
                end else state <= S_INS;
              end
              OP_DEL_LAST: begin
                if (count == '0) begin
                  status <= ST_MISS; state <= S_DONE;
                end else state <= S_DLAST;
              end
              default: begin
                if (count == '0) begin
                  status <= ST_MISS; state <= S_DONE;
                end else state <= S_SCAN;
              end
            endcase
          end
        end
        S_INS: begin
          // Entry 0 was read while idle, so idx never waits for data.
          if (!primed) begin
            primed <= 1'b1;
          end
          if (primed || idx == '0) begin
            carry <= rdata;
            if (idx == count) begin
              count <= count + CW'(1);
              state <= S_DONE;
            end
            idx <= idx + CW'(1);
          end
        end
        S_DLAST: begin
          if (!primed) primed <= 1'b1;
          else begin
            removed <= rdata;
            count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          // rdata is entry idx; the head was read while idle.
          if (rdata == val) begin
            if (op == OP_SEARCH) state <= S_DONE;
            else if (idx + CW'(1) >= count) begin
              status <= ST_MISS; state <= S_DONE;
            end else begin
              idx <= idx + CW'(1);
              found <= 1'b1;
              state <= S_SHIFT;
            end
          end else if (idx + CW'(1) >= count) begin
            status <= ST_MISS; state <= S_DONE;
          end else idx <= idx + CW'(1);
        end
        S_SHIFT: begin
          // First cycle: rdata = entry idx (the victim); then walk.
          if (found) begin
            removed <= rdata;
            found <= 1'b0;
          end else if (idx + CW'(1) >= count) begin
            count <= count - CW'(1);
            state <= S_DONE;
          end else idx <= idx + CW'(1);
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {1'b0, 5'(count), removed, status};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/ole_checker.sv =====
// Port-level checker for ordered_list_engine_core, bound to the top level.
// Depends on nothing but the top level's ports.
`default_nettype none
module ole_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat dropped while stalled");
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[38:34] <= 5'd16)
    else $error("entry count beyond depth");
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == 2'd2 |-> m_tdata[33:2] == 32'd0)
    else $error("full status with removed value");
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");
endmodule

bind ordered_list_engine_core ole_checker u_ole_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// ===== tb/ordered_list_engine_core_checker.sv =====
// Checker for the ordered list engine: watches both streams, predicts each
// result from its own copy of the list and compares field by field.
// Depends on ole_pkg.
`default_nettype none
module ordered_list_engine_core_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [39:0] m_tdata,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ole_pkg::*;

  localparam int ListDepth = DepthDefault;

  typedef struct packed {
    status_t     status;
    logic [31:0] removed;
    logic [4:0]  count;
  } list_result_t;

  logic [31:0]  list_vals[ListDepth];
  int           list_len;
  list_result_t result_queue[$];

  assign pending = result_queue.size();

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic int find_first(input logic [31:0] v);
    int i;
    for (i = 0; i < list_len; i++) if (list_vals[i] == v) return i;
    return list_len;
  endfunction

  // Apply one request to the model list and return the expected result.
  function automatic list_result_t apply_request(input op_t op, input logic [31:0] v);
    list_result_t r;
    int i, m;
    r.status = ST_OK;
    r.removed = '0;
    case (op)
      OP_INSERT: begin
        if (list_len >= ListDepth) r.status = ST_FULL;
        else begin
          for (i = list_len; i > 0; i--) list_vals[i] = list_vals[i-1];
          list_vals[0] = v;
          list_len++;
        end
      end
      OP_DEL_LAST: begin
        if (list_len == 0) r.status = ST_MISS;
        else begin
          list_len--;
          r.removed = list_vals[list_len];
        end
      end
      OP_SEARCH: begin
        if (find_first(v) >= list_len) r.status = ST_MISS;
      end
      default: begin
        m = find_first(v);
        if (m + 1 >= list_len) r.status = ST_MISS;
        else begin
          r.removed = list_vals[m+1];
          for (i = m + 1; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
    endcase
    r.count = 5'(list_len);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      list_len <= 0;
      fail_count <= 0;
      result_queue.delete();
    end else begin
      if (s_tvalid && s_tready)
        result_queue.push_back(apply_request(op_t'(s_tdata[1:0]), s_tdata[33:2]));
      if (m_tvalid && m_tready) begin
        if (result_queue.size() == 0) report("result beat with nothing expected");
        else begin
          want = result_queue.pop_front();
          if (m_tdata[1:0] != want.status)
            report($sformatf("status %0d, want %0d", m_tdata[1:0], want.status));
          if (m_tdata[33:2] != want.removed)
            report($sformatf("removed %0h, want %0h", m_tdata[33:2], want.removed));
          if (m_tdata[38:34] != want.count)
            report($sformatf("count %0d, want %0d", m_tdata[38:34], want.count));
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/ordered_list_engine_core_test.sv =====
// Top of the ordered list engine bench: drives requests in bursts, stalls
// the result side and gives the verdict. Depends on ole_pkg, core, checker.
`default_nettype none
module ordered_list_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ole_pkg::*;

  localparam int RandomCount = 1200;
  localparam int CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  logic [31:0] recent_vals[8];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ordered_list_engine_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  ordered_list_engine_core_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver stall pattern: phases of always-ready, random, and mostly-stalled.
  always @(posedge clk) begin
    case ((cycle_count / 300) % 3)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      default: m_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Present one beat, hold it until accepted, then maybe leave a gap.
  task automatic send_request(input op_t op, input logic [31:0] v, input bit last_of_burst);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, v, op};
    do @(posedge clk); while (!s_tready);
    recent_vals[$urandom_range(0, 7)] = v;
    if (last_of_burst) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($urandom_range(0, 7));
      default: return recent_vals[$urandom_range(0, 7)];
    endcase
  endfunction

  initial begin
    int i, burst, k;
    op_t op;
    for (i = 0; i < 8; i++) recent_vals[i] = 32'(i);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: empty misses, fill past full, extremes, duplicates, tail match.
    send_request(OP_DEL_LAST, 32'h0, 1'b0);
    send_request(OP_SEARCH, 32'h0, 1'b0);
    send_request(OP_DEL_AFTER, 32'h0, 1'b1);
    send_request(OP_INSERT, 32'h8000_0000, 1'b0);
    send_request(OP_DEL_AFTER, 32'h8000_0000, 1'b0);
    send_request(OP_INSERT, 32'h7fff_ffff, 1'b0);
    send_request(OP_INSERT, 32'h7fff_ffff, 1'b0);
    send_request(OP_SEARCH, 32'h8000_0000, 1'b0);
    send_request(OP_DEL_AFTER, 32'h7fff_ffff, 1'b1);
    send_request(OP_DEL_AFTER, 32'h1234_5678, 1'b0);
    for (i = 0; i < 15; i++) send_request(OP_INSERT, 32'hffff_fff0 + 32'(i), i == 14);
    send_request(OP_INSERT, 32'hffff_ffff, 1'b0);
    send_request(OP_SEARCH, 32'hffff_fff7, 1'b0);
    send_request(OP_DEL_LAST, 32'h0, 1'b1);
    // Random: bursts; alternate blocks favour inserts so full and empty recur.
    k = 0;
    while (k < RandomCount) begin
      burst = $urandom_range(1, 20);
      for (i = 0; i < burst && k < RandomCount; i++, k++) begin
        op = op_t'($urandom_range(0, 3));
        if ((k / 200) % 2 == 0 && $urandom_range(0, 2) == 0) op = OP_INSERT;
        send_request(op, pick_value(), i == burst - 1);
      end
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
